// File: src/tcw_pkg.sv
// Package for the text console writer: screen geometry, field widths,
// command codes and the structs passed between modules. No dependencies.
package tcw_pkg;

  localparam int ROWS      = 25;
  localparam int COLS      = 80;
  localparam int NCELLS    = ROWS * COLS;
  localparam int LAST_BASE = (ROWS - 1) * COLS;

  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;
  localparam int CMD_W  = 2;

  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_COLOR_RST = 8'h04;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              scrolled;
    logic [CELL_W-1:0] cell_data;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } result_t;

endpackage

// File: src/text_console_writer_top.sv
// Top level of the text console writer: attribute register, result register,
// sequencer and screen store. Depends on tcw_pkg, tcw_ctrl, tcw_screen_ram.
// One item at a time: a command is taken only when the sequencer is idle and
// the result register is free or being read. A scroll moves one cell per read
// and write pair.
// Synchronous active-high reset homes the cursor and sets the attribute to 4.
module text_console_writer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,  // char_color
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // char_code[7:0], cell_index[18:8], zero pad
  input  logic [1:0]  s_tuser,    // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata     // cursor_col[6:0], cursor_row[11:7],
                                  // cell_data[27:12], scrolled[28], zero pad
);
  import tcw_pkg::*;

  logic [CHAR_W-1:0] char_color;
  logic              out_free, done;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;
  result_t           result;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_color <= CHAR_COLOR_RST;
    end else if (cfg_we) begin
      char_color <= cfg_wdata;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .cmd        (s_tuser),
    .char_code  (s_tdata[7:0]),
    .cell_index (s_tdata[18:8]),
    .char_color (char_color),
    .out_free   (out_free),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .done       (done),
    .result     (result)
  );

  tcw_screen_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= {3'b000, result};
    end
  end

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> out_free)
    else $error("input taken while result register is held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done |-> out_free)
    else $error("result produced over a pending result");

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken before the first completed");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.cursor_row < ROW_W'(ROWS)) && (result.cursor_col < COL_W'(COLS)))
    else $error("cursor out of screen");

endmodule

// File: src/tcw_screen_ram.sv
// Screen store: one write port and one registered read port.
// Depends on tcw_pkg for depth and widths.
module tcw_screen_ram (
  input  logic                  clk,
  input  tcw_pkg::mem_req_t     req,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [NCELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: src/tcw_ctrl.sv
// Sequencer for the text console writer: cursor, shared address adder,
// scroll copy and blanking sweeps. Depends on tcw_pkg.
module tcw_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tcw_pkg::CMD_W-1:0]  cmd,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
  input  logic [tcw_pkg::CHAR_W-1:0] char_color,
  input  logic                       out_free,
  output tcw_pkg::mem_req_t          mem_req,
  input  logic [tcw_pkg::CELL_W-1:0] mem_rdata,
  output logic                       done,
  output tcw_pkg::result_t           result
);
  import tcw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_PUT     = 7'b0000010,
    S_SCR_RD  = 7'b0000100,
    S_SCR_WR  = 7'b0001000,
    S_BLANK   = 7'b0010000,
    S_RD      = 7'b0100000,
    S_RD_DATA = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ADDR_W-1:0] line_base, line_base_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              scr, scr_next;
  logic [CMD_W-1:0]  cmd_q;
  logic [CHAR_W-1:0] code_q;
  logic [IDX_W-1:0]  idx_q;

  logic [ADDR_W-1:0] add_a, add_b, sum;
  logic              printable, idx_ok, accept;

  assign in_ready  = (state == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign printable = !code_q[7] && (code_q[6:5] != 2'b00);
  assign idx_ok    = ({1'b0, idx_q} < (IDX_W+1)'(NCELLS));
  assign sum       = add_a + add_b;

  always_comb begin
    add_a = ptr;
    add_b = ADDR_W'(1);
    unique case (state)
      S_PUT: begin
        add_a = line_base;
        add_b = ADDR_W'(col);
      end
      S_SCR_RD: begin
        add_b = ADDR_W'(COLS);
      end
      default: begin
        add_b = ADDR_W'(1);
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    line_base_next = line_base;
    ptr_next       = ptr;
    scr_next       = scr;
    done           = 1'b0;
    mem_req.we     = 1'b0;
    mem_req.waddr  = ptr;
    mem_req.wdata  = {char_color, BLANK_CHAR};
    mem_req.raddr  = ADDR_W'(idx_q);
    result.cell_data = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          scr_next = 1'b0;
          ptr_next = '0;
          unique case (cmd_t'(cmd))
            CMD_PUT: state_next = S_PUT;
            CMD_CLEAR: begin
              col_next       = '0;
              row_next       = '0;
              line_base_next = '0;
              state_next     = S_BLANK;
            end
            default: state_next = S_RD;
          endcase
        end
      end
      S_PUT: begin
        mem_req.we    = printable;
        mem_req.waddr = sum;
        mem_req.wdata = {char_color, code_q};
        if (!printable || col == COL_W'(COLS - 1)) begin
          col_next = '0;
          if (row == ROW_W'(ROWS - 1)) begin
            scr_next   = 1'b1;
            state_next = S_SCR_RD;
          end else begin
            row_next       = row + ROW_W'(1);
            line_base_next = line_base + ADDR_W'(COLS);
            done           = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          col_next   = col + COL_W'(1);
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCR_RD: begin
        mem_req.raddr = sum;
        state_next    = S_SCR_WR;
      end
      S_SCR_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
        ptr_next      = sum;
        state_next    = (ptr == ADDR_W'(LAST_BASE - 1)) ? S_BLANK : S_SCR_RD;
      end
      S_BLANK: begin
        mem_req.we = 1'b1;
        ptr_next   = sum;
        if (ptr == ADDR_W'(NCELLS - 1)) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        state_next = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (cmd_q == CMD_READ && idx_ok) begin
          result.cell_data = mem_rdata;
        end
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    result.cursor_col = col_next;
    result.cursor_row = row_next;
    result.scrolled   = scr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      row       <= '0;
      line_base <= '0;
      scr       <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      line_base <= line_base_next;
      scr       <= scr_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (accept) begin
      cmd_q  <= cmd;
      code_q <= char_code;
      idx_q  <= cell_index;
    end
  end

endmodule
